/* sv/fsqrt_pkg.sv */
// Shared types, constants and functions for the single-precision square root.
package fsqrt_pkg;

	localparam int unsigned IterPerStage = 4;
	localparam int unsigned RootSteps = 24;
	localparam int unsigned NumStages = RootSteps / IterPerStage;
	localparam logic [31:0] QnanDefault = 32'h7FC0_0000;
	localparam logic [31:0] PosInf = 32'h7F80_0000;
	localparam logic [31:0] QuietMask = 32'h0040_0000;
	localparam logic [7:0] ExpBias = 8'd127;

	typedef enum logic [1:0] {
		RND_NEAR_EVEN = 2'd0,
		RND_ZERO      = 2'd1,
		RND_DOWN      = 2'd2,
		RND_UP        = 2'd3
	} round_mode_t;

	// Recurrence state; the remainder stays below 2^27, the partial root below 2^26.
	typedef struct packed {
		logic        special;
		logic [31:0] word;
		logic        invalid;
		logic [7:0]  exp;
		logic [25:0] q;
		logic [27:0] r;
		logic [24:0] s;
		round_mode_t mode;
	} sq_work_t;

	function automatic logic [4:0] lead_zeros24(input logic [23:0] v);
		logic [4:0] n;
		logic found;
		n = 5'd0;
		found = 1'b0;
		for (int b = 23; b >= 0; b--) begin
			if (v[b]) begin
				found = 1'b1;
			end else if (!found) begin
				n = n + 5'd1;
			end
		end
		return n;
	endfunction

endpackage

/* sv/fp32_square_root.sv */
// Top level of the pipelined IEEE single-precision square root.
// Usage:
//   Input channel in_valid/in_ready carries operand; output channel
//   out_valid/out_ready carries root, invalid_flag and inexact_flag.
//   rounding_mode is loaded from cfg_wdata[1:0] when cfg_we is high; write
//   it only while the pipeline is empty.
//   The pipeline has one stage for special case decode and normalization,
//   six stages of four root steps each, and one rounding stage that also
//   serves as the output register. Throughput is one transaction per cycle
//   while the output is not stalled; the stage count is set by the 24-step
//   root recurrence split four steps per stage.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds, bubbles included; in_ready is high whenever the output is empty
//   or being taken.
//   Reset clears all valid bits and sets the rounding mode to nearest even.
module fp32_square_root #(
	parameter int unsigned Stages = fsqrt_pkg::NumStages
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] operand,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] root,
	output logic        invalid_flag,
	output logic        inexact_flag,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata
);

	localparam int unsigned StepsPer = fsqrt_pkg::RootSteps / Stages;

	fsqrt_pkg::round_mode_t mode_q;
	logic en;
	logic valid_v [Stages+1];
	fsqrt_pkg::sq_work_t work_v [Stages+1];

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= fsqrt_pkg::RND_NEAR_EVEN;
		end else if (cfg_we) begin
			mode_q <= fsqrt_pkg::round_mode_t'(cfg_wdata);
		end
	end

	fsqrt_prep u_prep (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.operand(operand), .mode(mode_q),
		.valid_s1(valid_v[0]), .work_s1(work_v[0])
	);

	for (genvar g = 0; g < Stages; g++) begin : g_stage
		fsqrt_stage #(.Steps(StepsPer)) u_stage (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(valid_v[g]), .in_work(work_v[g]),
			.valid_q(valid_v[g+1]), .work_q(work_v[g+1])
		);
	end

	fsqrt_round u_round (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_v[Stages]), .in_work(work_v[Stages]),
		.valid_q(out_valid), .root_q(root),
		.invalid_q(invalid_flag), .inexact_q(inexact_flag)
	);

endmodule

/* sv/fsqrt_prep.sv */
// Input stage: special-case decode, normalization and exponent halving.
module fsqrt_prep (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [31:0]             operand,
	input  fsqrt_pkg::round_mode_t  mode,
	output logic                    valid_s1,
	output fsqrt_pkg::sq_work_t     work_s1
);

	logic        sgn;
	logic [7:0]  ex;
	logic [22:0] fx;
	logic [23:0] m;
	logic [4:0]  lz;
	logic [23:0] mn;
	logic signed [9:0] e;
	logic signed [9:0] half;
	logic [25:0] ms;
	fsqrt_pkg::sq_work_t w;

	always_comb begin
		sgn = operand[31];
		ex = operand[30:23];
		fx = operand[22:0];
		m = {(ex != 8'd0), fx};
		lz = fsqrt_pkg::lead_zeros24(m);
		mn = m << lz;
		e = $signed({2'b00, ex}) - 10'sd127 + ((ex == 8'd0) ? 10'sd1 : 10'sd0)
			- $signed({5'd0, lz});
		half = e >>> 1;
		ms = e[0] ? {mn, 2'b00} : {1'b0, mn, 1'b0};
		w = '0;
		w.mode = mode;
		w.special = 1'b1;
		if (ex == 8'd0 && fx == 23'd0) begin
			w.word = {sgn, 31'd0};
		end else if (ex == 8'hFF && fx == 23'd0 && !sgn) begin
			w.word = fsqrt_pkg::PosInf;
		end else if (sgn && !(ex == 8'hFF && fx != 23'd0)) begin
			w.word = fsqrt_pkg::QnanDefault;
			w.invalid = 1'b1;
		end else if (ex == 8'hFF) begin
			w.word = operand | fsqrt_pkg::QuietMask;
			w.invalid = !operand[22];
		end else begin
			w.special = 1'b0;
		end
		w.exp = 8'(half + $signed({2'b00, fsqrt_pkg::ExpBias}));
		w.q = 26'd1 << 24;
		w.r = {2'b00, ms} - (28'd1 << 24);
		w.s = 25'd1 << 24;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s1 <= w;
		end
	end

endmodule

/* sv/fsqrt_stage.sv */
// One pipeline stage of the restoring root recurrence.
module fsqrt_stage #(
	parameter int unsigned Steps = fsqrt_pkg::IterPerStage
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  fsqrt_pkg::sq_work_t in_work,
	output logic                valid_q,
	output fsqrt_pkg::sq_work_t work_q
);

	fsqrt_pkg::sq_work_t w;
	logic [28:0] t;

	always_comb begin
		w = in_work;
		t = '0;
		for (int i = 0; i < Steps; i++) begin
			w.s = w.s >> 1;
			t = {w.r, 1'b0} - {2'b00, w.q, 1'b0} - {4'd0, w.s};
			if (t[28]) begin
				w.r = {w.r[26:0], 1'b0};
			end else begin
				w.q = w.q + {1'b0, w.s};
				w.r = t[27:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_q <= w;
		end
	end

endmodule

/* sv/fsqrt_round.sv */
// Output stage: rounding and result assembly.
module fsqrt_round (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  fsqrt_pkg::sq_work_t in_work,
	output logic                valid_q,
	output logic [31:0]         root_q,
	output logic                invalid_q,
	output logic                inexact_q
);

	logic [22:0] fz;
	logic rnd, stk, incr;
	logic [31:0] z;
	logic inx;

	always_comb begin
		fz = in_work.q[23:1];
		rnd = in_work.q[0];
		stk = in_work.r != 28'd0;
		case (in_work.mode)
			fsqrt_pkg::RND_NEAR_EVEN: incr = rnd && (stk || fz[0]);
			fsqrt_pkg::RND_UP:        incr = rnd || stk;
			default:                  incr = 1'b0;
		endcase
		if (in_work.special) begin
			z = in_work.word;
			inx = 1'b0;
		end else begin
			z = {1'b0, in_work.exp, fz} + {31'd0, incr};
			inx = rnd || stk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_q <= z;
			invalid_q <= in_work.invalid;
			inexact_q <= inx;
		end
	end

endmodule

/* sv/fsqrt_checker.sv */
// Port-level assertions for the square root, bound to the top level.
module fsqrt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] root,
	input logic        invalid_flag,
	input logic        inexact_flag
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(root))
		else $error("result dropped or changed under stall");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output stall");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(invalid_flag && inexact_flag))
		else $error("invalid and inexact both set");

	a_invalid_nan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid_flag |-> root[30:22] == 9'h1FF)
		else $error("invalid result is not a quiet NaN");

endmodule

bind fp32_square_root fsqrt_checker u_fsqrt_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .root(root),
	.invalid_flag(invalid_flag), .inexact_flag(inexact_flag)
);
